### sv/text_line_framer_with_taint_top_macros.svh
// assertion macros for the text line framer
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef TEXT_LINE_FRAMER_WITH_TAINT_TOP_MACROS_SVH
`define TEXT_LINE_FRAMER_WITH_TAINT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TLF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLF_ASSERT(label, ante, cons, msg)
`define TLF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### sv/tlf_pkg.sv
// shared types and constants of the text line framer
// no dependencies
package tlf_pkg;

  // line store geometry
  localparam int unsigned LINE_DEPTH  = 64;
  localparam int unsigned LEN_W       = $clog2(LINE_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W      = LEN_W + 1;
  localparam int unsigned RAM_DEPTH   = 2 ** ADDR_W;
  localparam int unsigned CHAR_W      = 7;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] PRINT_LOW = 8'h20;
  localparam logic [7:0] PRINT_END = 8'h7f;

  typedef enum logic [1:0] {
    OP_CONT  = 2'd0,
    OP_START = 2'd1,
    OP_LINK  = 2'd2,
    OP_IDLE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] line_byte;
    logic              line_last;
  } out_t;

  // finished line waiting to be drained
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } ent_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_t;

endpackage

### sv/tlf_ram.sv
// generic simple dual-port ram with registered, enabled read
// no dependencies
module tlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tlf_front.sv
// front end: accepts bytes, classifies them, fills the line store
// depends on tlf_pkg
module tlf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  tlf_pkg::in_t  in_req_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output logic          push_o,
  output tlf_pkg::ent_t push_ent_o,
  output tlf_pkg::wr_t  wr_o
);

  logic [tlf_pkg::LEN_W-1:0] len_q, len_d, len_eff;
  logic                      taint_q, taint_d, taint_eff;
  logic                      wbank_q, wbank_d;
  logic                      accept;
  logic [7:0]                rx;

  // both banks pending means the write bank is still being drained
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign rx         = in_req_i.rx_byte;

  // classify the request and update the partial line
  always_comb begin
    len_d      = len_q;
    taint_d    = taint_q;
    len_eff    = len_q;
    taint_eff  = taint_q;
    push_o     = 1'b0;
    push_ent_o = '{bank: wbank_q, len: len_q};
    wr_o       = '{en: 1'b0, addr: {wbank_q, len_q}, data: rx[tlf_pkg::CHAR_W-1:0]};
    if (accept) begin
      case (tlf_pkg::op_e'(in_req_i.op))
        tlf_pkg::OP_LINK: begin
          len_d   = '0;
          taint_d = 1'b0;
        end
        tlf_pkg::OP_CONT, tlf_pkg::OP_START: begin
          // a new event drops a tainted partial line first
          if ((tlf_pkg::op_e'(in_req_i.op) == tlf_pkg::OP_START) && taint_q) begin
            len_eff   = '0;
            taint_eff = 1'b0;
          end
          len_d   = len_eff;
          taint_d = taint_eff;
          if (rx == tlf_pkg::CH_CR) begin
            len_d = len_eff;
          end else if (rx == tlf_pkg::CH_LF) begin
            push_o     = (len_eff != '0) && !taint_eff;
            push_ent_o = '{bank: wbank_q, len: len_eff};
            len_d      = '0;
            taint_d    = 1'b0;
          end else if ((rx < tlf_pkg::PRINT_LOW) || (rx >= tlf_pkg::PRINT_END)) begin
            taint_d = 1'b1;
          end else if (len_eff < tlf_pkg::LEN_W'(tlf_pkg::LINE_DEPTH - 1)) begin
            wr_o.en   = 1'b1;
            wr_o.addr = {wbank_q, len_eff};
            len_d     = tlf_pkg::LEN_W'(len_eff + tlf_pkg::LEN_W'(1));
          end else begin
            taint_d = 1'b1;
          end
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  // switch banks after each emitted line
  assign wbank_d = wbank_q ^ push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      taint_q <= 1'b0;
      wbank_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      taint_q <= taint_d;
      wbank_q <= wbank_d;
    end
  end

endmodule

### sv/tlf_fifo.sv
// short queue of finished lines between front and back
// depends on tlf_pkg
module tlf_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  tlf_pkg::ent_t              push_ent_i,
  input  logic                       pop_i,
  output tlf_pkg::ent_t              head_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [tlf_pkg::QCNT_W-1:0] count_o
);

  tlf_pkg::ent_t              ent_q [tlf_pkg::QUEUE_DEPTH];
  logic [tlf_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [tlf_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == tlf_pkg::QCNT_W'(tlf_pkg::QUEUE_DEPTH));
  assign head_o  = ent_q[rptr_q];
  assign count_o = cnt_q;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = tlf_pkg::QCNT_W'(cnt_q + tlf_pkg::QCNT_W'(1));
    end else if (pop_i && !push_i) begin
      cnt_d = tlf_pkg::QCNT_W'(cnt_q - tlf_pkg::QCNT_W'(1));
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_ent_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= tlf_pkg::QPTR_W'(wptr_q + tlf_pkg::QPTR_W'(1));
      end
      if (pop_i) begin
        rptr_q <= tlf_pkg::QPTR_W'(rptr_q + tlf_pkg::QPTR_W'(1));
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/tlf_back.sv
// back end: drains queued lines from the store, one character per cycle while the output is not stalled
// depends on tlf_pkg; the ram read register serves as the output register
module tlf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  tlf_pkg::ent_t head_i,
  output logic          pop_o,
  output tlf_pkg::rd_t  rd_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          last_o
);

  logic [tlf_pkg::LEN_W-1:0] idx_q, idx_d;
  logic                      vld_q, vld_d;
  logic                      last_q, last_d;
  logic                      issue, is_last;

  // read the next character whenever the output slot frees up
  assign issue   = !q_empty_i && (!vld_q || !out_stall_i);
  assign is_last = (tlf_pkg::LEN_W'(idx_q + tlf_pkg::LEN_W'(1)) == head_i.len);
  assign pop_o   = issue && is_last;
  assign rd_o    = '{en: issue, addr: {head_i.bank, idx_q}};

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && out_stall_i;
    last_d = last_q;
    if (issue) begin
      idx_d  = is_last ? '0 : tlf_pkg::LEN_W'(idx_q + tlf_pkg::LEN_W'(1));
      vld_d  = 1'b1;
      last_d = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      vld_q  <= vld_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = vld_q;
  assign last_o      = last_q;

endmodule

### sv/text_line_framer_with_taint_top.sv
// top level of the text line framer: front, line queue, back and line store
// depends on tlf_pkg, tlf_front, tlf_fifo, tlf_back, tlf_ram and the macros header

// Newline-delimited text line framer. One received byte is taken per cycle
// while the input is not stalled; printable characters go into one of two
// line banks of the store, carriage returns are skipped, and a control or
// high byte, or a character that would exceed LINE_DEPTH-1, taints the line.
// On a newline a clean non-empty line is queued and the back end sends it
// out at one character per cycle while the output is not stalled, through
// the store's registered read port, with line_last on the final character.
// The input stalls only while both banks hold lines still waiting to be
// sent; it then waits until the older line has been read out, which a
// stalled output delays. No clearing pass is needed after reset.
`include "text_line_framer_with_taint_top_macros.svh"

module text_line_framer_with_taint_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tlf_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tlf_pkg::out_t out_req_o
);

  logic                       push, pop, q_empty, q_full, last;
  logic [tlf_pkg::QCNT_W-1:0] q_count;
  tlf_pkg::ent_t              push_ent, head;
  tlf_pkg::wr_t               wr;
  tlf_pkg::rd_t               rd;
  logic [tlf_pkg::CHAR_W-1:0] rdata;

  // front end
  tlf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_ent_o (push_ent),
    .wr_o       (wr)
  );

  // finished line queue
  tlf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full),
    .count_o    (q_count)
  );

  // back end
  tlf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .rd_o        (rd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .last_o      (last)
  );

  // two-bank line store
  tlf_ram #(
    .WIDTH (tlf_pkg::CHAR_W),
    .DEPTH (tlf_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  assign out_req_o = '{line_byte: rdata, line_last: last};

  // checks
  `TLF_ASSERT(a_bank_split, wr.en && rd.en, wr.addr[tlf_pkg::ADDR_W-1] != rd.addr[tlf_pkg::ADDR_W-1], "write and drain hit the same bank")
  `TLF_ASSERT(a_push_room, push, q_count != tlf_pkg::QCNT_W'(tlf_pkg::QUEUE_DEPTH), "line queued while queue full")
  `TLF_ASSERT_NEXT(a_pop_last, pop, out_valid_o && out_req_o.line_last, "line retired without last character shown")

endmodule

### tb/tb_text_line_framer_with_taint_top.sv
`timescale 1ns / 1ps
// self-checking testbench for text_line_framer_with_taint_top
// depends on tlf_pkg and the framer rtl; predicts every line character in place
module tb_text_line_framer_with_taint_top;

  localparam int HOLD_CYCLES = 300;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  tlf_pkg::in_t  in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  tlf_pkg::out_t out_req_o;

  text_line_framer_with_taint_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // requests waiting to be driven and line characters waiting to come out
  tlf_pkg::in_t  pending_reqs[$];
  tlf_pkg::out_t line_chars_due[$];

  // predicted line state
  logic [7:0]  line_buf [tlf_pkg::LINE_DEPTH];
  int unsigned line_fill;
  bit          line_dirty;

  int            errors;
  bit            req_taken;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            hold_arm;
  int            hold_cnt;
  tlf_pkg::out_t want;

  // clock
  always #10 clk_i = ~clk_i;

  // track one accepted request through the framer behavior
  task automatic frame_request(tlf_pkg::in_t req);
    logic [7:0]    c;
    tlf_pkg::out_t o;
    c = req.rx_byte;
    case (req.op)
      tlf_pkg::OP_LINK: begin
        line_fill  = 0;
        line_dirty = 1'b0;
      end
      tlf_pkg::OP_CONT, tlf_pkg::OP_START: begin
        // a new receive event drops a tainted partial line
        if (req.op == tlf_pkg::OP_START && line_dirty) begin
          line_fill  = 0;
          line_dirty = 1'b0;
        end
        if (c == tlf_pkg::CH_CR) begin
        end else if (c == tlf_pkg::CH_LF) begin
          if (line_fill > 0 && !line_dirty) begin
            for (int i = 0; i < line_fill; i++) begin
              o.line_byte = line_buf[tlf_pkg::LEN_W'(i)][tlf_pkg::CHAR_W-1:0];
              o.line_last = (i + 1 == line_fill);
              line_chars_due.push_back(o);
            end
          end
          line_fill  = 0;
          line_dirty = 1'b0;
        end else if (c < tlf_pkg::PRINT_LOW || c >= tlf_pkg::PRINT_END) begin
          line_dirty = 1'b1;
        end else if (line_fill < tlf_pkg::LINE_DEPTH - 1) begin
          line_buf[tlf_pkg::LEN_W'(line_fill)] = c;
          line_fill++;
        end else begin
          line_dirty = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // monitor: predict accepted requests, check accepted line characters
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) frame_request(in_req_i);
      if (out_valid_o && !out_stall_i) begin
        if (line_chars_due.size() == 0) begin
          $display("%0t: unexpected character: expected none, got byte %h last %b",
                   $time, out_req_o.line_byte, out_req_o.line_last);
          errors++;
        end else begin
          want = line_chars_due.pop_front();
          if (out_req_o.line_byte !== want.line_byte) begin
            $display("%0t: line_byte mismatch: expected %h, got %h",
                     $time, want.line_byte, out_req_o.line_byte);
            errors++;
          end
          if (out_req_o.line_last !== want.line_last) begin
            $display("%0t: line_last mismatch: expected %b, got %b",
                     $time, want.line_last, out_req_o.line_last);
            errors++;
          end
        end
      end
    end
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver: hold a stalled request, otherwise offer the next one or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: one long hold-off when armed, random stalls otherwise
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      hold_cnt    <= 0;
      out_stall_i <= 1'b0;
    end else if (hold_arm && hold_cnt < HOLD_CYCLES) begin
      hold_cnt    <= hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_req(tlf_pkg::op_e op, logic [7:0] b);
    tlf_pkg::in_t r;
    r.op      = op;
    r.rx_byte = b;
    pending_reqs.push_back(r);
  endtask

  // one line of len characters and its newline; noisy adds returns and bad bytes
  task automatic push_line(int len, bit noisy);
    int         r;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (noisy && r < 4) b = tlf_pkg::CH_CR;
      else if (noisy && r < 7) b = 8'($urandom_range(1) ? $urandom_range(0, 31)
                                                        : $urandom_range(127, 255));
      else b = 8'($urandom_range(32, 126));
      push_req(i == 0 ? tlf_pkg::OP_START : tlf_pkg::OP_CONT, b);
    end
    push_req($urandom_range(9) == 0 ? tlf_pkg::OP_START : tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
  endtask

  // random traffic: mostly lines, some loose requests of any op
  task automatic push_traffic(int target);
    int           made;
    int           r;
    int           len;
    tlf_pkg::in_t q;
    made = 0;
    while (made < target) begin
      r = $urandom_range(99);
      if (r < 12) begin
        q.op      = 2'($urandom_range(3));
        q.rx_byte = 8'($urandom_range(255));
        pending_reqs.push_back(q);
        if (q.op != tlf_pkg::OP_IDLE) made++;
      end else begin
        r   = $urandom_range(99);
        len = r < 70 ? $urandom_range(1, 8) : r < 94 ? $urandom_range(9, 30)
                                                     : $urandom_range(58, 66);
        push_line(len, 1'b1);
        made += len + 1;
      end
    end
  endtask

  // wait until every request is in and every expected character is out
  task automatic drain();
    @(posedge clk_i);
    while (pending_reqs.size() > 0 || in_valid_i || line_chars_due.size() > 0)
      @(posedge clk_i);
  endtask

  // timeout
  initial begin
    #20_000_000;
    $display("tb_text_line_framer_with_taint_top: FAIL");
    $finish;
  end

  // test sequence
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    out_stall_i   = 1'b0;
    errors        = 0;
    req_taken     = 1'b0;
    hold_arm      = 1'b0;
    line_fill     = 0;
    line_dirty    = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 59;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: return skipped, empty line, unused op, printable extremes
    push_req(tlf_pkg::OP_START, "A");
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_CR);
    push_req(tlf_pkg::OP_CONT, "b");
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
    push_req(tlf_pkg::OP_IDLE, "x");
    push_req(tlf_pkg::OP_START, 8'h7e);
    push_req(tlf_pkg::OP_CONT, 8'h20);
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
    // control byte taints, line dropped at newline
    push_req(tlf_pkg::OP_CONT, "q");
    push_req(tlf_pkg::OP_CONT, 8'h1f);
    push_req(tlf_pkg::OP_CONT, "r");
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
    // delete code taints, new event discards the tainted part
    push_req(tlf_pkg::OP_CONT, 8'h7f);
    push_req(tlf_pkg::OP_START, "z");
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
    // a high byte and a control byte taint, new event on the newline itself
    push_req(tlf_pkg::OP_CONT, 8'hff);
    push_req(tlf_pkg::OP_CONT, 8'h00);
    push_req(tlf_pkg::OP_START, tlf_pkg::CH_LF);
    // link connect clears the partial line, its byte ignored
    push_req(tlf_pkg::OP_CONT, "k");
    push_req(tlf_pkg::OP_LINK, tlf_pkg::CH_LF);
    push_req(tlf_pkg::OP_CONT, "m");
    push_req(tlf_pkg::OP_CONT, tlf_pkg::CH_LF);
    push_req(tlf_pkg::OP_LINK, 8'haa);
    drain();

    // longest clean line, then one character too many
    push_line(tlf_pkg::LINE_DEPTH - 1, 1'b0);
    push_line(tlf_pkg::LINE_DEPTH, 1'b0);
    drain();
    push_traffic(20);
    drain();

    // sender slow, receiver fast
    send_idle_pct = 59;
    recv_idle_pct = 7;
    push_traffic(20);
    drain();

    // no idling; long receiver hold-off while lines keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_arm <= 1'b1;
    for (int i = 0; i < 6; i++) push_line(8, 1'b0);
    drain();
    push_traffic(20);
    drain();

    repeat (40) @(posedge clk_i);
    if (errors == 0 && line_chars_due.size() == 0) begin
      $display("tb_text_line_framer_with_taint_top: PASS");
    end else begin
      $display("tb_text_line_framer_with_taint_top: FAIL");
    end
    $finish;
  end

endmodule
